>>> rtl/core/bbf_pkg.sv
// ----------------------------------------------------------------------------
// bbf_pkg
// Shared constants, item kind codes and status types for the blocked Bloom
// filter engine.
// ----------------------------------------------------------------------------
package bbf_pkg;

   localparam int WORD_W         = 64;
   localparam int SLOT_W         = 5;
   localparam int DEF_BLOCKS     = 4096;
   localparam int DEF_MASK_COUNT = 1024;
   localparam int DEF_MASK_BITS  = 57;
   localparam int QUEUE_DEPTH    = 4;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_LOAD   = 2'd0;
   localparam kind_type KIND_INSERT = 2'd1;
   localparam kind_type KIND_QUERY  = 2'd2;

   // back part status seen by the front part
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

>>> rtl/core/bbf_ifs.sv
// ----------------------------------------------------------------------------
// bbf channel interfaces
// Valid/ready channels for hash items and filter responses.
// ----------------------------------------------------------------------------
interface bbf_req_if;
   logic                         valid;
   logic                         ready;
   bbf_pkg::kind_type            kind;
   logic [bbf_pkg::WORD_W-1:0]   hash;
   logic [bbf_pkg::SLOT_W-1:0]   table_slot;
   logic [bbf_pkg::WORD_W-1:0]   table_word;
   logic                         batch_end;

   modport source (output valid, kind, hash, table_slot, table_word, batch_end,
                   input ready);
   modport sink   (input valid, kind, hash, table_slot, table_word, batch_end,
                   output ready);
endinterface

interface bbf_rsp_if;
   logic valid;
   logic ready;
   logic present;
   logic last_of_batch;

   modport source (output valid, present, last_of_batch, input ready);
   modport sink   (input valid, present, last_of_batch, output ready);
endinterface

>>> rtl/core/bbf_front.sv
// ----------------------------------------------------------------------------
// bbf_front
// Accepts items, loads the mask table, reads the two table words a hash
// needs and builds the rotated mask and block index for the back part.
// ----------------------------------------------------------------------------
module bbf_front #(
   parameter int BLOCKS     = bbf_pkg::DEF_BLOCKS,
   parameter int MASK_COUNT = bbf_pkg::DEF_MASK_COUNT,
   parameter int MASK_BITS  = bbf_pkg::DEF_MASK_BITS,
   parameter int BLK_W      = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
   parameter int ENTRY_W    = 2 + bbf_pkg::WORD_W + BLK_W + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   bbf_req_if.sink                  req_chan,
   input  bbf_pkg::back_status_type status,
   input  logic                     q_ready,
   output logic                     q_push,
   output logic [ENTRY_W-1:0]       q_data
);

   localparam int MASK_WORDS = (MASK_COUNT - 1) / 64 + 2;
   localparam int TW         = $clog2(MASK_WORDS);
   localparam int START_W    = $clog2(MASK_COUNT);
   localparam int LG         = $clog2(MASK_COUNT + 1) - 1;
   localparam logic [bbf_pkg::WORD_W-1:0] FULL =
      (bbf_pkg::WORD_W'(1) << MASK_BITS) - bbf_pkg::WORD_W'(1);

   typedef struct packed {
      bbf_pkg::kind_type       kind;
      logic [5:0]              off;
      logic [5:0]              rot;
      logic [BLK_W-1:0]        blk;
      logic                    last;
   } stage_type;

   typedef struct packed {
      bbf_pkg::kind_type           kind;
      logic [bbf_pkg::WORD_W-1:0]  mask;
      logic [BLK_W-1:0]            blk;
      logic                        last;
   } entry_type;

   logic [bbf_pkg::WORD_W-1:0] tbl_mem [MASK_WORDS];
   logic [bbf_pkg::WORD_W-1:0] t0_ff, t1_ff;
   logic                       s1_valid_ff, s1_valid_in;
   stage_type                  s1_ff, s1_in;

   logic                       accept;
   logic [START_W-1:0]         start;
   logic [TW-1:0]              word_lo, word_hi, slot_idx;
   logic                       tbl_we;
   logic [2*bbf_pkg::WORD_W-1:0] pair, dbl;
   logic [bbf_pkg::WORD_W-1:0] win;
   entry_type                  entry;

   assign q_push         = s1_valid_ff && q_ready;
   assign req_chan.ready = !status.clearing && (!s1_valid_ff || q_ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign start    = START_W'(req_chan.hash) & START_W'(MASK_COUNT - 1);
   assign word_lo  = TW'(start >> 6);
   assign word_hi  = word_lo + TW'(1);
   assign slot_idx = TW'(32'(req_chan.table_slot));
   assign tbl_we   = accept && (req_chan.kind == bbf_pkg::KIND_LOAD) &&
                     (32'(req_chan.table_slot) < MASK_WORDS);

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[slot_idx] <= req_chan.table_word;
      end
      if (accept) begin
         t0_ff <= tbl_mem[word_lo];
         t1_ff <= tbl_mem[word_hi];
      end
   end

   always_comb begin
      s1_in       = s1_ff;
      s1_valid_in = s1_valid_ff && !q_ready;
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_in.kind  = req_chan.kind;
         s1_in.off   = start[5:0];
         s1_in.rot   = 6'(req_chan.hash >> LG);
         s1_in.blk   = BLK_W'(req_chan.hash >> (LG + 6)) & BLK_W'(BLOCKS - 1);
         s1_in.last  = req_chan.batch_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   // window from the word pair, trimmed, then rotated left
   always_comb begin
      pair       = {t1_ff, t0_ff};
      win        = bbf_pkg::WORD_W'(pair >> s1_ff.off) & FULL;
      dbl        = {win, win} << s1_ff.rot;
      entry.kind = s1_ff.kind;
      entry.mask = dbl[2*bbf_pkg::WORD_W-1:bbf_pkg::WORD_W];
      entry.blk  = s1_ff.blk;
      entry.last = s1_ff.last;
   end

   assign q_data = entry;

endmodule

>>> rtl/core/bbf_queue.sv
// ----------------------------------------------------------------------------
// bbf_queue
// Small FIFO between the front and back parts.
// ----------------------------------------------------------------------------
module bbf_queue #(
   parameter int DATA_W = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              push_ready,
   input  logic              pop,
   output logic              pop_valid,
   output logic [DATA_W-1:0] pop_data
);

   localparam int DEPTH = bbf_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != CW'(0));
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/bbf_back.sv
// ----------------------------------------------------------------------------
// bbf_back
// Owns the filter block store: clears it after reset, then performs the
// read-modify-write of inserts and the subset test of queries.
// ----------------------------------------------------------------------------
module bbf_back #(
   parameter int BLOCKS  = bbf_pkg::DEF_BLOCKS,
   parameter int BLK_W   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1,
   parameter int ENTRY_W = 2 + bbf_pkg::WORD_W + BLK_W + 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  logic [ENTRY_W-1:0]       q_data,
   output logic                     q_pop,
   bbf_rsp_if.source                rsp_chan,
   output bbf_pkg::back_status_type status
);

   typedef struct packed {
      bbf_pkg::kind_type           kind;
      logic [bbf_pkg::WORD_W-1:0]  mask;
      logic [BLK_W-1:0]            blk;
      logic                        last;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   logic [bbf_pkg::WORD_W-1:0] blk_mem [BLOCKS];
   logic [bbf_pkg::WORD_W-1:0] blk_rd_ff;

   state_type                  state_ff, state_in;
   logic [BLK_W-1:0]           clr_ff, clr_in;
   entry_type                  cur_ff, cur_in, head;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       present_ff, present_in;
   logic                       last_ff, last_in;

   logic                       mem_re, mem_we;
   logic [BLK_W-1:0]           mem_waddr;
   logic [bbf_pkg::WORD_W-1:0] mem_wdata;
   logic                       hit;

   assign head            = q_data;
   assign status.clearing = (state_ff == ST_CLEAR);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.present       = present_ff;
   assign rsp_chan.last_of_batch = last_ff;

   assign hit = ((blk_rd_ff & cur_ff.mask) == cur_ff.mask);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      present_in   = present_ff;
      last_in      = last_ff;
      q_pop        = 1'b0;
      mem_re       = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = cur_ff.blk;
      mem_wdata    = blk_rd_ff | cur_ff.mask;
      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + BLK_W'(1);
            if (clr_ff == BLK_W'(BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            // take the next entry only if the response slot frees up
            if (q_valid && (!rsp_valid_ff || rsp_chan.ready)) begin
               q_pop    = 1'b1;
               mem_re   = 1'b1;
               cur_in   = head;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            mem_we       = (cur_ff.kind == bbf_pkg::KIND_INSERT);
            rsp_valid_in = 1'b1;
            present_in   = (cur_ff.kind == bbf_pkg::KIND_QUERY) && hit;
            last_in      = cur_ff.last;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         blk_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         blk_rd_ff <= blk_mem[head.blk];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff     <= cur_in;
      present_ff <= present_in;
      last_ff    <= last_in;
   end

endmodule

>>> rtl/core/blocked_bloom_filter_engine.sv
// ----------------------------------------------------------------------------
// blocked_bloom_filter_engine
// Register-blocked Bloom filter: mask table loads, inserts and queries over
// a store of 64-bit filter blocks, one response per item.
// ----------------------------------------------------------------------------
// Path: an item passes the front stage, the queue and the back part's read state, then
//   its response is registered. The back part finishes each item's block store read and
//   write-back before it takes the next; the front queues up to 5 items ahead.
// Reset: control clears at once; a clearing pass then zeroes the block store,
//   one block a cycle over all BLOCKS blocks (4096 by default), with req ready low.
module blocked_bloom_filter_engine #(
   parameter int BLOCKS     = bbf_pkg::DEF_BLOCKS,
   parameter int MASK_COUNT = bbf_pkg::DEF_MASK_COUNT,
   parameter int MASK_BITS  = bbf_pkg::DEF_MASK_BITS
) (
   input  logic       clock,
   input  logic       reset,
   bbf_req_if.sink    req_chan,
   bbf_rsp_if.source  rsp_chan
);

   localparam int BLK_W   = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int ENTRY_W = 2 + bbf_pkg::WORD_W + BLK_W + 1;

   bbf_pkg::back_status_type status;
   logic                     q_push, q_ready, q_pop, q_valid;
   logic [ENTRY_W-1:0]       q_in_data, q_out_data;

   bbf_front #(
      .BLOCKS     (BLOCKS),
      .MASK_COUNT (MASK_COUNT),
      .MASK_BITS  (MASK_BITS),
      .BLK_W      (BLK_W),
      .ENTRY_W    (ENTRY_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .status   (status),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_data   (q_in_data)
   );

   bbf_queue #(
      .DATA_W (ENTRY_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_in_data),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_data   (q_out_data)
   );

   bbf_back #(
      .BLOCKS  (BLOCKS),
      .BLK_W   (BLK_W),
      .ENTRY_W (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_data   (q_out_data),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan),
      .status   (status)
   );

endmodule

>>> rtl/core/bbf_checker.sv
// ----------------------------------------------------------------------------
// bbf_checker
// Port-level checks of the blocked Bloom filter engine, bound to the top.
// ----------------------------------------------------------------------------
module bbf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic present
);

   logic [3:0] pending_ff, pending_in;
   logic       req_xfer, rsp_xfer;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_xfer   = rsp_valid && rsp_ready;
   assign pending_in = pending_ff + 4'(req_xfer) - 4'(rsp_xfer);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // no response without an item still owed one
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 4'd0))
      else $error("response with no outstanding item");

   // block store clearing holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("input ready during clearing pass");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(present))
      else $error("response payload changed while stalled");

endmodule

bind blocked_bloom_filter_engine bbf_checker u_bbf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .present   (rsp_chan.present)
);

>>> dv/blocked_bloom_filter_engine_tb.sv
// ----------------------------------------------------------------------------
// blocked_bloom_filter_engine_tb
// Self-checking bench for the blocked Bloom filter engine. Drives mask table
// loads, inserts, queries and unused kinds with random idle and stall on both
// channels. A local filter model computes the expected present and
// last_of_batch for every accepted transfer, in order.
// ----------------------------------------------------------------------------
module blocked_bloom_filter_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam bbf_pkg::kind_type KIND_UNUSED = 2'd3;
   localparam int       LG_MASKS     = $clog2(bbf_pkg::DEF_MASK_COUNT);
   localparam int       TABLE_WORDS  = (bbf_pkg::DEF_MASK_COUNT - 1) / 64 + 2;
   localparam logic [63:0] WIN_FULL  = (64'd1 << bbf_pkg::DEF_MASK_BITS) - 64'd1;
   localparam int       IDLE_PCT     = 37;

   typedef struct packed {
      bbf_pkg::kind_type                kind;
      logic [bbf_pkg::WORD_W-1:0]       hash;
      logic [bbf_pkg::SLOT_W-1:0]       slot;
      logic [bbf_pkg::WORD_W-1:0]       word;
      logic                             batch_end;
   } filter_item_type;

   typedef struct packed {
      logic present;
      logic last;
   } filter_answer_type;

   logic clock;
   logic reset;

   bbf_req_if req_if ();
   bbf_rsp_if rsp_if ();

   blocked_bloom_filter_engine dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   // filter model state
   logic [63:0]       mask_words [TABLE_WORDS];
   logic [63:0]       filter_store [bbf_pkg::DEF_BLOCKS];
   filter_answer_type answers_due [$];
   logic [63:0]       inserted_keys [$];
   int                mismatches = 0;
   bit                no_idle = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #1ms;
      $display("blocked_bloom_filter_engine_tb NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // filter model
   // ------------------------------------------------------------------
   function automatic logic [63:0] mask_of(logic [63:0] h);
      int unsigned start;
      int unsigned w;
      int unsigned off;
      int unsigned rot;
      logic [127:0] pair;
      logic [63:0]  win;
      logic [127:0] dbl;
      start = h[31:0] & 32'(bbf_pkg::DEF_MASK_COUNT - 1);
      w     = start >> 6;
      off   = start & 32'd63;
      pair  = {mask_words[w + 1], mask_words[w]} >> off;
      win   = pair[63:0] & WIN_FULL;
      rot   = 32'((h >> LG_MASKS) & 64'd63);
      dbl   = {win, win} << rot;
      return dbl[127:64];
   endfunction

   function automatic int unsigned block_of(logic [63:0] h);
      return 32'((h >> (LG_MASKS + 6)) & 64'(bbf_pkg::DEF_BLOCKS - 1));
   endfunction

   function automatic filter_answer_type filter_predict(filter_item_type it);
      filter_answer_type ans;
      logic [63:0]       m;
      int unsigned       blk;
      ans.present = 1'b0;
      ans.last    = it.batch_end;
      case (it.kind)
         bbf_pkg::KIND_LOAD: begin
            if (it.slot < TABLE_WORDS) mask_words[it.slot] = it.word;
         end
         bbf_pkg::KIND_INSERT: begin
            m   = mask_of(it.hash);
            blk = block_of(it.hash);
            filter_store[blk] = filter_store[blk] | m;
         end
         bbf_pkg::KIND_QUERY: begin
            m   = mask_of(it.hash);
            blk = block_of(it.hash);
            ans.present = ((filter_store[blk] & m) == m);
         end
         default: ;
      endcase
      return ans;
   endfunction

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------
   function automatic filter_item_type load_item(int slot, logic [63:0] word, bit last);
      filter_item_type it;
      it.kind      = bbf_pkg::KIND_LOAD;
      it.hash      = {$urandom, $urandom};
      it.slot      = bbf_pkg::SLOT_W'(slot);
      it.word      = word;
      it.batch_end = last;
      return it;
   endfunction

   function automatic filter_item_type hash_item(bbf_pkg::kind_type kind, logic [63:0] h,
                                                 bit last);
      filter_item_type it;
      it.kind      = kind;
      it.hash      = h;
      it.slot      = bbf_pkg::SLOT_W'($urandom);
      it.word      = {$urandom, $urandom};
      it.batch_end = last;
      return it;
   endfunction

   // send one item; valid stays high after the transfer until the next call
   task automatic send_item(filter_item_type it);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid = 1'b0;
         req_if.hash  = {$urandom, $urandom};
         @(negedge clock);
      end
      req_if.kind       = it.kind;
      req_if.hash       = it.hash;
      req_if.table_slot = it.slot;
      req_if.table_word = it.word;
      req_if.batch_end  = it.batch_end;
      req_if.valid      = 1'b1;
      do @(posedge clock); while (!req_if.ready);
      answers_due.push_back(filter_predict(it));
   endtask

   // keys land mostly on a few hot blocks so inserts pile up and queries hit
   function automatic logic [63:0] shaped_key();
      logic [63:0] h;
      h = {$urandom, $urandom};
      if ($urandom_range(9) < 7) h[27:16] = 12'($urandom_range(7) * 585);
      return h;
   endfunction

   function automatic filter_item_type random_item();
      int          r;
      logic [63:0] h;
      logic [63:0] w;
      bit          last;
      int          slot;
      r    = $urandom_range(99);
      last = ($urandom_range(3) == 0);
      if (r < 4) begin
         slot = ($urandom_range(99) < 85) ? $urandom_range(0, 16)
                                          : $urandom_range(17, 31);
         w    = {$urandom, $urandom};
         if ($urandom_range(2) == 0)
            w = w & {$urandom, $urandom} & {$urandom, $urandom};
         return load_item(slot, w, last);
      end
      if (r < 7) return hash_item(KIND_UNUSED, {$urandom, $urandom}, last);
      if (r < 47) begin
         h = shaped_key();
         inserted_keys.push_back(h);
         if (inserted_keys.size() > 64) void'(inserted_keys.pop_front());
         return hash_item(bbf_pkg::KIND_INSERT, h, last);
      end
      r = $urandom_range(99);
      if (inserted_keys.size() != 0 && r < 70) begin
         h = inserted_keys[$urandom_range(inserted_keys.size() - 1)];
         if (r >= 50) h[$urandom_range(63)] ^= 1'b1;
      end else begin
         h = shaped_key();
      end
      return hash_item(bbf_pkg::KIND_QUERY, h, last);
   endfunction

   // ------------------------------------------------------------------
   // response side
   // ------------------------------------------------------------------
   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_if.ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin : check_rsp
      filter_answer_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (answers_due.size() == 0) begin
            report_mismatch("response transfer with no item pending");
         end else begin
            want = answers_due.pop_front();
            if (rsp_if.present !== want.present)
               report_mismatch($sformatf("present %b, expected %b",
                                         rsp_if.present, want.present));
            if (rsp_if.last_of_batch !== want.last)
               report_mismatch($sformatf("last_of_batch %b, expected %b",
                                         rsp_if.last_of_batch, want.last));
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // zero window: only words 0 and 1 are loaded, so keep the start in word 0
   task automatic test_empty_mask();
      send_item(load_item(0, 64'd0, 1'b0));
      send_item(load_item(1, 64'd0, 1'b1));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  64'hFFFF_FFFF_FFFF_FC00, 1'b0));
      send_item(hash_item(bbf_pkg::KIND_INSERT, 64'hFFFF_FFFF_FFFF_FC00, 1'b1));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  64'h0000_0000_0000_003F, 1'b1));
   endtask

   task automatic test_table_load();
      for (int s = 0; s < TABLE_WORDS; s++)
         send_item(load_item(s, (s == 0 || s == TABLE_WORDS - 1) ? '1 : {$urandom, $urandom},
                             s == TABLE_WORDS - 1));
      // out-of-range slots and the unused kind change nothing
      send_item(load_item(TABLE_WORDS, {$urandom, $urandom}, 1'b0));
      send_item(load_item(31, 64'd0, 1'b1));
      send_item(hash_item(KIND_UNUSED, '1, 1'b1));
   endtask

   task automatic test_insert_query();
      send_item(hash_item(bbf_pkg::KIND_QUERY,  64'd0, 1'b0));
      send_item(hash_item(bbf_pkg::KIND_INSERT, 64'd0, 1'b0));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  64'd0, 1'b1));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  '1,    1'b0));
      send_item(hash_item(bbf_pkg::KIND_INSERT, '1,    1'b0));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  '1,    1'b1));
      send_item(hash_item(bbf_pkg::KIND_QUERY,  64'h0000_0000_0FFF_0155, 1'b0));
   endtask

   task automatic test_random(int count);
      repeat (count) send_item(random_item());
   endtask

   task automatic test_back_to_back(int count);
      no_idle = 1;
      repeat (count) send_item(random_item());
      no_idle = 0;
   endtask

   initial begin
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.kind       = bbf_pkg::KIND_LOAD;
      req_if.hash       = '0;
      req_if.table_slot = '0;
      req_if.table_word = '0;
      req_if.batch_end  = 1'b0;
      foreach (mask_words[i]) mask_words[i] = '0;
      foreach (filter_store[i]) filter_store[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_mask();
      test_table_load();
      test_insert_query();
      test_random(450);
      test_back_to_back(150);
      test_random(420);

      @(negedge clock);
      req_if.valid = 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (mismatches == 0) begin
         $display("blocked_bloom_filter_engine_tb OK");
      end else begin
         $display("blocked_bloom_filter_engine_tb NOT OK");
      end
      $finish;
   end

endmodule

>>> blocked_bloom_filter_engine.f
rtl/core/bbf_pkg.sv
rtl/core/bbf_ifs.sv
rtl/core/bbf_front.sv
rtl/core/bbf_queue.sv
rtl/core/bbf_back.sv
rtl/core/blocked_bloom_filter_engine.sv
rtl/core/bbf_checker.sv
dv/blocked_bloom_filter_engine_tb.sv
